// ===== rtl/vtp_pkg.sv =====
// Shared types and constants for the vertex transform and projection block.
// Used by the row datapath, the divider cells and the top level.
package vtp_pkg;

  localparam int unsigned NumRegs    = 3;
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DivBits    = 32;
  localparam int unsigned RowSumBits = 36;
  localparam int unsigned TransBits  = 21;

  localparam logic [15:0] HalfScreen = 16'd128;
  localparam logic [15:0] SatPos     = 16'h7fff;
  localparam logic [15:0] SatNeg     = 16'h8000;
  // Largest positive quotient that still fits after adding the screen offset.
  localparam logic [31:0] PosLimit   = 32'd32639;
  localparam logic [31:0] NegLimit   = 32'd32768;

  typedef enum logic [1:0] {
    RegRowX = 2'd0,
    RegRowY = 2'd1,
    RegRowZ = 2'd2,
    RegNone = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FaultOk   = 2'd0,
    FaultZero = 2'd1,
    FaultOvf  = 2'd2,
    FaultRsvd = 2'd3
  } fault_e;

  // Payload moving down the divider chain: both lanes share one divisor.
  typedef struct packed {
    logic [15:0] den;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [31:0] nx;
    logic [31:0] ny;
    logic        qneg_x;
    logic        qneg_y;
    logic        nneg_x;
    logic        nneg_y;
    logic        zero;
    logic [15:0] depth;
  } div_t;

endpackage

// ===== rtl/vtp_row.sv =====
// One matrix row in Winograd form: products, then row sum and translation.
// Depends on vtp_pkg.
module vtp_row (
  input  logic                            clk_i,
  input  logic [63:0]                     row_i,
  input  logic signed [15:0]              x_i,
  input  logic signed [15:0]              y_i,
  input  logic signed [15:0]              z_i,
  input  logic signed [31:0]              xy_i,
  output logic signed [vtp_pkg::RowSumBits-1:0] sum_o,
  output logic signed [vtp_pkg::TransBits-1:0]  trans_o
);
  import vtp_pkg::*;

  logic signed [15:0] a, b, c, tw;
  logic signed [16:0] ay, bx;
  logic signed [33:0] p1_d, p1_q;
  logic signed [31:0] p2_d, p2_q;
  logic signed [31:0] pab_d, pab_q;
  logic signed [RowSumBits-1:0] sum_d;
  logic signed [TransBits-1:0]  trans_d;

  assign a  = row_i[15:0];
  assign b  = row_i[31:16];
  assign c  = row_i[47:32];
  assign tw = row_i[63:48];

  always_comb begin
    ay    = 17'(a) + 17'(y_i);
    bx    = 17'(b) + 17'(x_i);
    p1_d  = 34'(ay) * 34'(bx);
    p2_d  = 32'(c) * 32'(z_i);
    pab_d = 32'(a) * 32'(b);
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    pab_q <= pab_d;
  end

  always_comb begin
    sum_d   = RowSumBits'(p1_q) + RowSumBits'(p2_q) - RowSumBits'(xy_i);
    // drop the a*b term, kept in 8.12 form
    trans_d = TransBits'(tw) - TransBits'(pab_q >>> 12);
  end

  always_ff @(posedge clk_i) begin
    sum_o   <= sum_d;
    trans_o <= trans_d;
  end

endmodule

// ===== rtl/vtp_div_cell.sv =====
// One restoring divider cell: retires one quotient bit of both lanes.
// Depends on vtp_pkg.
module vtp_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  vtp_pkg::div_t d_i,
  output logic          valid_o,
  output vtp_pkg::div_t d_o
);
  import vtp_pkg::*;

  logic [16:0] shx, shy, den_w;
  logic        gex, gey;
  div_t        d_d;

  always_comb begin
    d_d   = d_i;
    den_w = {1'b0, d_i.den};
    shx   = {d_i.rx, d_i.nx[31]};
    shy   = {d_i.ry, d_i.ny[31]};
    gex   = shx >= den_w;
    gey   = shy >= den_w;
    d_d.rx = gex ? 16'(shx - den_w) : shx[15:0];
    d_d.ry = gey ? 16'(shy - den_w) : shy[15:0];
    // shift the dividend out and the quotient bit in
    d_d.nx = {d_i.nx[30:0], gex};
    d_d.ny = {d_i.ny[30:0], gey};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_o <= d_d;
  end

endmodule

// ===== rtl/vertex_transform_project.sv =====
// Top level: APB register file, three row datapaths, divider cell chain
// and output saturation. Depends on vtp_pkg, vtp_row and vtp_div_cell.
//
// Usage:
//   Program the three 64-bit matrix rows over APB at byte addresses 0, 8
//   and 16 while the block is idle. pready is always high; reads return
//   the register. Only writes to addresses 24 to 31 are dropped.
//   Drive vertex_x/y/z with start high for one cycle per vertex; busy is
//   never raised, so a new vertex may start in every cycle.
//   Each vertex yields one result: done_o is high for one
//   cycle with screen_x, screen_y, view_depth and fault.
//   Pipeline: registered multiply, row sum, scaling and operand preparation
//   stages, 32 divider cells (one quotient bit each), one saturation stage.
//   Throughput: one vertex per cycle.
//   Reset clears the matrix rows and drops every transfer in flight.
//   The receiver cannot stall; results are presented once and not held.
module vertex_transform_project (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [vtp_pkg::AddrWidth-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  input  logic signed [15:0] vertex_z_i,
  output logic               done_o,
  output logic signed [15:0] screen_x_o,
  output logic signed [15:0] screen_y_o,
  output logic signed [15:0] view_depth_o,
  output logic [1:0]         fault_o
);
  import vtp_pkg::*;

  typedef struct packed {
    logic [15:0] val;
    logic        ovf;
  } lane_t;

  logic [63:0] row_q [NumRegs];
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign widx   = reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) row_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        RegRowX: row_q[0] <= pwdata;
        RegRowY: row_q[1] <= pwdata;
        RegRowZ: row_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      RegRowX: prdata = row_q[0];
      RegRowY: prdata = row_q[1];
      RegRowZ: prdata = row_q[2];
      default: prdata = '0;
    endcase
  end

  // Stage 1: shared x*y product
  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [31:0] xy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xy_q <= 32'(vertex_x_i) * 32'(vertex_y_i);
  end

  logic signed [RowSumBits-1:0] sum_w [NumRegs];
  logic signed [TransBits-1:0]  trans_w [NumRegs];

  for (genvar r = 0; r < NumRegs; r++) begin : g_row
    vtp_row u_row (
      .clk_i   (clk_i),
      .row_i   (row_q[r]),
      .x_i     (vertex_x_i),
      .y_i     (vertex_y_i),
      .z_i     (vertex_z_i),
      .xy_i    (xy_q),
      .sum_o   (sum_w[r]),
      .trans_o (trans_w[r])
    );
  end

  // Stage 3: scale rows, wrap depth
  logic [31:0] nx_q, ny_q;
  logic [15:0] zp_q;

  always_ff @(posedge clk_i) begin
    nx_q <= sum_w[0][35:4] + {{3{trans_w[0][20]}}, trans_w[0], 8'b0};
    ny_q <= sum_w[1][35:4] + {{3{trans_w[1][20]}}, trans_w[1], 8'b0};
    zp_q <= sum_w[2][27:12] + trans_w[2][15:0];
  end

  // Stage 4: magnitudes and signs into the divider
  div_t div_d, div_q;

  always_comb begin
    div_d        = '0;
    div_d.zero   = zp_q == 16'd0;
    div_d.depth  = zp_q;
    div_d.den    = zp_q[15] ? 16'(-zp_q) : zp_q;
    div_d.nneg_x = nx_q[31];
    div_d.nneg_y = ny_q[31];
    div_d.qneg_x = nx_q[31] ^ zp_q[15];
    div_d.qneg_y = ny_q[31] ^ zp_q[15];
    div_d.nx     = nx_q[31] ? 32'(-nx_q) : nx_q;
    div_d.ny     = ny_q[31] ? 32'(-ny_q) : ny_q;
    div_d.rx     = '0;
    div_d.ry     = '0;
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  logic cv [DivBits+1];
  div_t cd [DivBits+1];

  assign cv[0] = v4_q;
  assign cd[0] = div_q;

  for (genvar k = 0; k < DivBits; k++) begin : g_cell
    vtp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .d_i     (cd[k]),
      .valid_o (cv[k+1]),
      .d_o     (cd[k+1])
    );
  end

  function automatic lane_t saturate(input logic [31:0] uq, input logic qneg,
                                     input logic nneg, input logic zero);
    lane_t res;
    res = '0;
    if (zero) begin
      res.val = nneg ? SatNeg : SatPos;
    end else if (qneg) begin
      if (uq > NegLimit) begin
        res.val = 16'(SatNeg + HalfScreen);
        res.ovf = 1'b1;
      end else begin
        res.val = HalfScreen - uq[15:0];
      end
    end else begin
      if (uq > PosLimit) begin
        res.val = SatPos;
        res.ovf = 1'b1;
      end else begin
        res.val = uq[15:0] + HalfScreen;
      end
    end
    return res;
  endfunction

  div_t   fin;
  lane_t  lx, ly;
  fault_e fault_d;

  assign fin = cd[DivBits];

  always_comb begin
    lx = saturate(fin.nx, fin.qneg_x, fin.nneg_x, fin.zero);
    ly = saturate(fin.ny, fin.qneg_y, fin.nneg_y, fin.zero);
    priority if (fin.zero) fault_d = FaultZero;
    else if (lx.ovf || ly.ovf) fault_d = FaultOvf;
    else fault_d = FaultOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cv[DivBits];
    end
  end

  always_ff @(posedge clk_i) begin
    screen_x_o   <= lx.val;
    screen_y_o   <= ly.val;
    view_depth_o <= fin.depth;
    fault_o      <= fault_d;
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for vertex_transform_project: drives vertices and APB matrix writes
// and checks each result against a built-in transform and projection predictor.
// Depends on vtp_pkg and the RTL of vertex_transform_project.
module tb_top;
  import vtp_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 50;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] depth;
    fault_e             fault;
  } proj_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [15:0] vertex_x_i = '0, vertex_y_i = '0, vertex_z_i = '0;
  logic done_o;
  logic signed [15:0] screen_x_o, screen_y_o, view_depth_o;
  logic [1:0] fault_o;

  logic [63:0] matrix_row [3];
  proj_t       pending_proj [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;

  vertex_transform_project u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint coef(logic [63:0] row, int k);
    return longint'($signed(row[16*k +: 16]));
  endfunction

  function automatic longint winograd_sum(logic [63:0] row, longint x, longint y, longint z);
    return (coef(row, 0) + y) * (coef(row, 1) + x) + coef(row, 2) * z - x * y;
  endfunction

  function automatic longint row_bias(logic [63:0] row);
    return coef(row, 3) - ((coef(row, 0) * coef(row, 1)) >>> 12);
  endfunction

  function automatic longint screen_coord(longint num, longint den, inout fault_e f);
    longint q;
    if (den == 0) begin
      f = FaultZero;
      return (num >= 0) ? 32767 : -32768;
    end
    q = num / den;
    if (q > 32767 || q < -32768) begin
      q = (q > 0) ? 32767 : -32768;
      if (f == FaultOk) f = FaultOvf;
    end
    q = q + 128;
    if (q > 32767) begin
      q = 32767;
      if (f == FaultOk) f = FaultOvf;
    end
    return q;
  endfunction

  function automatic proj_t project_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                           logic signed [15:0] vz);
    longint x, y, z, r;
    logic [31:0] nx, ny;
    logic signed [15:0] d;
    fault_e f;
    proj_t p;
    x = vx;
    y = vy;
    z = vz;
    r = (winograd_sum(matrix_row[RegRowX], x, y, z) >>> 4) + row_bias(matrix_row[RegRowX]) * 256;
    nx = r[31:0];
    r = (winograd_sum(matrix_row[RegRowY], x, y, z) >>> 4) + row_bias(matrix_row[RegRowY]) * 256;
    ny = r[31:0];
    r = (winograd_sum(matrix_row[RegRowZ], x, y, z) >>> 12) + row_bias(matrix_row[RegRowZ]);
    d = r[15:0];
    f = FaultOk;
    p.sx = 16'(screen_coord(longint'($signed(nx)), longint'(d), f));
    p.sy = 16'(screen_coord(longint'($signed(ny)), longint'(d), f));
    p.depth = d;
    p.fault = f;
    return p;
  endfunction

  // Predict on each accepted transfer, check each strobed result.
  always @(posedge clk_i) begin
    proj_t want;
    cycles <= cycles + 1;
    if (rst_ni && start_i && !busy_o) pending_proj.push_back(project_vertex(vertex_x_i,
                                                              vertex_y_i, vertex_z_i));
    if (rst_ni && done_o) begin
      if (pending_proj.size() == 0) begin
        $display("%0t: unexpected result sx=%0d sy=%0d depth=%0d fault=%0d", $realtime,
                 screen_x_o, screen_y_o, view_depth_o, fault_o);
        errors++;
      end else begin
        want = pending_proj.pop_front();
        if (screen_x_o !== want.sx || screen_y_o !== want.sy ||
            view_depth_o !== want.depth || fault_o !== want.fault) begin
          $display("%0t: expected sx=%0d sy=%0d depth=%0d fault=%0d, got %0d %0d %0d %0d",
                   $realtime, want.sx, want.sy, want.depth, want.fault,
                   screen_x_o, screen_y_o, view_depth_o, fault_o);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("vertex_transform_project: mismatch");
      $finish;
    end
  end

  // Stop sending, then hold until every expected result has arrived.
  task automatic drain();
    start_i <= 1'b0;
    while (pending_proj.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Write one matrix row; index RegNone must be dropped by the block.
  task automatic write_row(reg_idx_e idx, logic [63:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'(idx) << 3;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx != RegNone) matrix_row[idx] = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
    logic was_busy;
    int unsigned gap;
    start_i <= 1'b1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    vertex_z_i <= z;
    do begin
      @(negedge clk_i) was_busy = busy_o;
      @(posedge clk_i);
    end while (was_busy);
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] pack_row(int a, int b, int c, int t);
    return {16'(t), 16'(c), 16'(b), 16'(a)};
  endfunction

  task automatic test_reset_matrix();
    // All rows zero: depth is zero, both coordinates saturate high.
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(-16'sd32768, 16'sd32767, -16'sd1);
  endtask

  task automatic test_extremes();
    logic signed [15:0] ext [4] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
    write_row(RegRowX, pack_row(4096, 0, 0, 3));
    write_row(RegRowY, pack_row(0, 4096, 0, -5));
    write_row(RegRowZ, pack_row(0, 0, 4096, 7));
    for (int i = 0; i < 4; i++) send_vertex(ext[i], ext[3-i], ext[(i+1)%4]);
    // Nonzero a*b term exercises the row correction.
    write_row(RegRowX, pack_row(-32768, -32768, 32767, -32768));
    write_row(RegRowY, pack_row(32767, 32767, -32768, 32767));
    write_row(RegRowZ, pack_row(-32768, 32767, 32767, 1));
    for (int i = 0; i < 4; i++) send_vertex(ext[i], ext[i], ext[3-i]);
  endtask

  task automatic test_saturation();
    write_row(RegRowZ, pack_row(0, 0, 0, 1));
    write_row(RegRowX, pack_row(0, 0, 0, 128));   // quotient 32768 overflows
    write_row(RegRowY, pack_row(0, 0, 0, -129));  // quotient below the negative bound
    send_vertex(16'sd1, 16'sd2, 16'sd3);
    write_row(RegRowX, pack_row(0, 0, 0, 127));
    write_row(RegRowY, pack_row(0, 0, 0, -128));
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    write_row(RegRowZ, pack_row(0, 0, 0, 2));
    write_row(RegRowX, pack_row(0, 0, 0, 255));   // fits, but not with the screen offset
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    write_row(RegRowZ, pack_row(0, 0, 0, 0));     // zero depth, negative y numerator
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    write_row(RegNone, {$urandom, $urandom});     // must be dropped
    send_vertex(16'sd5, -16'sd5, 16'sd9);
  endtask

  task automatic random_matrix();
    if ($urandom_range(3) == 0) begin
      for (int r = 0; r < 3; r++) write_row(reg_idx_e'(r), {$urandom, $urandom});
    end else begin
      // Moderate coefficients, and a depth row translation from 256 to 32256.
      for (int r = 0; r < 2; r++)
        write_row(reg_idx_e'(r), pack_row($urandom_range(8192) - 4096,
                  $urandom_range(8192) - 4096, $urandom_range(8192) - 4096,
                  $urandom_range(200) - 100));
      write_row(RegRowZ, pack_row($urandom_range(64) - 32, $urandom_range(64) - 32,
                $urandom_range(64) - 32, $urandom_range(32000) + 256));
    end
  endtask

  task automatic test_random(int unsigned pct, int unsigned count);
    idle_pct = pct;
    random_matrix();
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 75 == 74) random_matrix();
      else if ($urandom_range(49) == 0) drain();
      send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
    end
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    for (int r = 0; r < 3; r++) matrix_row[r] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_matrix();
    test_extremes();
    test_saturation();
    start_i <= 1'b0;
    @(posedge clk_i);
    test_random(0, 250);
    test_random(64, 250);
    test_random(0, 200);
    test_random(15, 200);
    drain();
    if (errors == 0) begin
      $display("vertex_transform_project: match");
    end else begin
      $display("vertex_transform_project: mismatch");
    end
    $finish;
  end

endmodule
